>>> rtl/vrd_pkg.sv
// Shared constants, types and helpers of the varint run-length delta frame decoder.
package vrd_pkg;

  localparam int unsigned MaxWidthDef  = 640;
  localparam int unsigned MaxHeightDef = 360;

  localparam int unsigned ByteBits   = 8;
  localparam int unsigned WordBits   = 32;
  localparam int unsigned GroupBits  = 7;
  localparam int unsigned ContBit    = 7;
  localparam int unsigned LastGroup  = 4;
  localparam int unsigned ShiftCap   = 28;
  localparam int unsigned GroupIdxW  = 3;

  localparam int unsigned OutBits    = 18;
  localparam int unsigned QueueDepth = 4;

  localparam int unsigned CfgWidthBits  = 10;
  localparam int unsigned CfgHeightBits = 9;
  localparam int unsigned ResetWidth    = 480;
  localparam int unsigned ResetHeight   = 360;

  localparam int unsigned ApbAddrBits = 3;
  localparam int unsigned ApbDataBits = 32;

  typedef enum logic {
    RegFrameWidth  = 1'b0,
    RegFrameHeight = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic               run_valid;
    logic [OutBits-1:0] run_start;
    logic [OutBits-1:0] run_length;
    logic               frame_end;
  } vrd_result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } vrd_queue_stat_t;

  function automatic logic [4:0] group_shift(input logic [GroupIdxW-1:0] idx);
    logic [4:0] sh;
    case (idx)
      3'd0:    sh = 5'd0;
      3'd1:    sh = 5'(GroupBits);
      3'd2:    sh = 5'(2 * GroupBits);
      3'd3:    sh = 5'(3 * GroupBits);
      default: sh = 5'(ShiftCap);
    endcase
    return sh;
  endfunction

endpackage

>>> rtl/vrd_if.sv
// Valid/ready stream interfaces for the coded byte input and the run result output.
interface vrd_byte_if
  import vrd_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [ByteBits-1:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface vrd_run_if
  import vrd_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               run_valid;
  logic [OutBits-1:0] run_start;
  logic [OutBits-1:0] run_length;
  logic               frame_end;

  modport source (output valid, output run_valid, output run_start, output run_length,
                  output frame_end, input ready);
  modport sink (input valid, input run_valid, input run_start, input run_length,
                input frame_end, output ready);
endinterface

>>> rtl/vrd_front.sv
// Front end: accepts stream words and assembles base-128 varints.
module vrd_front
  import vrd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  vrd_byte_if.sink            stream,
  input  vrd_queue_stat_t     stat_i,
  output logic                push_o,
  output logic [WordBits-1:0] push_word_o
);

  logic [GroupIdxW-1:0] group_q, group_d;
  logic [WordBits-1:0]  accum_q, accum_d;
  logic [WordBits-1:0]  shifted;
  logic [WordBits-1:0]  merged;
  logic                 last_group;
  logic                 take;

  assign stream.ready = !stat_i.full;
  assign take         = stream.valid && !stat_i.full;

  assign shifted    = {{(WordBits-GroupBits){1'b0}}, stream.stream_byte[GroupBits-1:0]}
                      << group_shift(group_q);
  assign merged     = accum_q | shifted;
  assign last_group = !stream.stream_byte[ContBit] || (group_q >= GroupIdxW'(LastGroup));

  assign push_o      = take && last_group;
  assign push_word_o = merged;

  always_comb begin
    group_d = group_q;
    accum_d = accum_q;
    if (take) begin
      if (last_group) begin
        group_d = '0;
        accum_d = '0;
      end else begin
        group_d = group_q + GroupIdxW'(1);
        accum_d = merged;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '0;
      accum_q <= '0;
    end else begin
      group_q <= group_d;
      accum_q <= accum_d;
    end
  end

  a_group_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    group_q <= GroupIdxW'(LastGroup))
    else $error("varint group index beyond fifth byte");

  a_fifth_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (group_q == GroupIdxW'(LastGroup)) |-> push_o)
    else $error("fifth varint byte did not close the varint");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (group_q == '0) && (accum_q == '0))
    else $error("accumulator not cleared after varint");

endmodule

>>> rtl/vrd_queue.sv
// Short register queue of completed varints between front and back end.
module vrd_queue
  import vrd_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [WordBits-1:0] push_word_i,
  input  logic                pop_i,
  output logic [WordBits-1:0] pop_word_o,
  output vrd_queue_stat_t     stat_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WordBits-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign stat_o.full  = (count_q == CntW'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_word_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue fill beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("push into full queue");

endmodule

>>> rtl/vrd_back.sv
// Back end: walks the runs of each frame and registers run results.
module vrd_back
  import vrd_pkg::*;
#(
  parameter int unsigned TOTAL_W = 18
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [WordBits-1:0] word_i,
  input  vrd_queue_stat_t     stat_i,
  output logic                pop_o,
  input  logic [TOTAL_W-1:0]  total_i,
  vrd_run_if.source           result
);

  logic                expect_q, expect_d;
  logic [WordBits-1:0] runs_left_q, runs_left_d;
  logic                toggle_q, toggle_d;
  logic [WordBits-1:0] pos_q, pos_d;
  logic                out_valid_q, out_valid_d;
  vrd_result_t         res_q, res_d;

  logic [WordBits:0]   pos_x;
  logic [WordBits:0]   sum_x;
  logic [WordBits:0]   tot_x;
  logic [WordBits:0]   len_x;
  logic                emit;
  logic                closing;
  logic                produce;
  vrd_result_t         res_new;

  assign pop_o   = !stat_i.empty && (!out_valid_q || result.ready);
  assign pos_x   = {1'b0, pos_q};
  assign sum_x   = pos_x + {1'b0, word_i};
  assign tot_x   = (WordBits + 1)'(total_i);
  assign emit    = toggle_q && (pos_x < tot_x);
  assign len_x   = (sum_x > tot_x) ? (tot_x - pos_x) : {1'b0, word_i};
  assign closing = (runs_left_q == WordBits'(1));

  always_comb begin
    expect_d    = expect_q;
    runs_left_d = runs_left_q;
    toggle_d    = toggle_q;
    pos_d       = pos_q;
    produce     = 1'b0;
    res_new     = '0;
    if (pop_o) begin
      if (expect_q) begin
        pos_d    = '0;
        toggle_d = 1'b0;
        if (word_i == '0) begin
          runs_left_d       = '0;
          produce           = 1'b1;
          res_new.frame_end = 1'b1;
        end else begin
          runs_left_d = word_i;
          expect_d    = 1'b0;
        end
      end else begin
        pos_d       = sum_x[WordBits] ? '1 : sum_x[WordBits-1:0];
        toggle_d    = !toggle_q;
        runs_left_d = runs_left_q - WordBits'(1);
        if (closing) begin
          expect_d = 1'b1;
          toggle_d = 1'b0;
          pos_d    = '0;
        end
        if (emit) begin
          produce            = 1'b1;
          res_new.run_valid  = 1'b1;
          res_new.run_start  = pos_q[OutBits-1:0];
          res_new.run_length = len_x[OutBits-1:0];
          res_new.frame_end  = closing;
        end else if (closing) begin
          produce           = 1'b1;
          res_new.frame_end = 1'b1;
        end
      end
    end
    out_valid_d = pop_o ? produce : (out_valid_q && !result.ready);
    res_d       = produce ? res_new : res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_q    <= 1'b1;
      runs_left_q <= '0;
      toggle_q    <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      expect_q    <= expect_d;
      runs_left_q <= runs_left_d;
      toggle_q    <= toggle_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result.valid      = out_valid_q;
  assign result.run_valid  = res_q.run_valid;
  assign result.run_start  = res_q.run_start;
  assign result.run_length = res_q.run_length;
  assign result.frame_end  = res_q.frame_end;

  a_runs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !expect_q |-> runs_left_q != '0)
    else $error("run phase with no runs left");

  a_count_no_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && expect_q |=> !(out_valid_q && res_q.run_valid))
    else $error("run count produced a toggle run");

  a_frame_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    expect_q |-> (pos_q == '0) && !toggle_q)
    else $error("frame state not cleared while awaiting run count");

endmodule

>>> rtl/varint_rle_delta_frame_decoder.sv
// Top level of the varint run-length delta frame decoder with its APB register file.
//
// Usage: coded stream words enter on stream_i, one byte per word, valid/ready.
// Each completed varint passes through a four-entry queue to the run walker.
// Results leave on result_o: a toggle run (run_valid, run_start, run_length)
// and/or the frame_end mark; varints that close no run and end no frame give
// no word. The APB port holds frame_width (address 0) and frame_height
// (address 4); write them only while the block is idle.
// Throughput: one stream word per cycle while the queue has room. The word that
// completes a varint is written into the queue when it is taken; the registered
// run walker (a 33-bit add and compare) then pops it and writes the result into
// the output register, from which it is visible on result_o.
// When result_o stalls, the output register holds its word, the queue fills
// and then stream_i drops ready; nothing is lost.
// Reset: frame size returns to 480 x 360, the decoder awaits a run count,
// queue and output register empty.
module varint_rle_delta_frame_decoder
  import vrd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  vrd_byte_if.sink               stream_i,
  vrd_run_if.source              result_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ApbAddrBits-1:0] paddr,
  input  logic [ApbDataBits-1:0] pwdata,
  output logic [ApbDataBits-1:0] prdata,
  output logic                   pready
);

  localparam int unsigned WDim    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HDim    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned ProdW   = WDim + HDim;
  localparam int unsigned TotalW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned RstW    = (ResetWidth > MAX_WIDTH) ? MAX_WIDTH : ResetWidth;
  localparam int unsigned RstH    = (ResetHeight > MAX_HEIGHT) ? MAX_HEIGHT : ResetHeight;
  localparam int unsigned RstTot  = RstW * RstH;

  logic [CfgWidthBits-1:0]  width_q;
  logic [CfgHeightBits-1:0] height_q;
  logic [WDim-1:0]          width_c;
  logic [HDim-1:0]          height_c;
  logic [ProdW-1:0]         prod;
  logic [TotalW-1:0]        total_q;
  logic                     cfg_wr;
  reg_idx_e                 cfg_idx;

  logic                     push;
  logic [WordBits-1:0]      push_word;
  logic                     pop;
  logic [WordBits-1:0]      pop_word;
  vrd_queue_stat_t          qstat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_comb begin
    case (cfg_idx)
      RegFrameWidth:  prdata = ApbDataBits'(width_q);
      RegFrameHeight: prdata = ApbDataBits'(height_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgWidthBits'(ResetWidth);
      height_q <= CfgHeightBits'(ResetHeight);
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegFrameWidth:  width_q  <= pwdata[CfgWidthBits-1:0];
        RegFrameHeight: height_q <= pwdata[CfgHeightBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      width_c = WDim'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      width_c = WDim'(MAX_WIDTH);
    end else begin
      width_c = WDim'(width_q);
    end
    if (height_q == '0) begin
      height_c = HDim'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      height_c = HDim'(MAX_HEIGHT);
    end else begin
      height_c = HDim'(height_q);
    end
  end

  assign prod = ProdW'(width_c) * ProdW'(height_c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TotalW'(RstTot);
    end else begin
      total_q <= prod[TotalW-1:0];
    end
  end

  vrd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stream      (stream_i),
    .stat_i      (qstat),
    .push_o      (push),
    .push_word_o (push_word)
  );

  vrd_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .pop_i       (pop),
    .pop_word_o  (pop_word),
    .stat_o      (qstat)
  );

  vrd_back #(
    .TOTAL_W (TotalW)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .word_i  (pop_word),
    .stat_i  (qstat),
    .pop_o   (pop),
    .total_i (total_q),
    .result  (result_o)
  );

endmodule
